// ----- src/tbp_pkg.sv -----
// Shared types and constants of the tournament branch predictor.
// No dependencies; the interfaces and the top level import it.
package tbp_pkg;

  localparam int WindowW    = 16;
  localparam int OutCountW  = 32;
  localparam int NumPred    = 7;
  localparam int PredIdxW   = 3;
  localparam int HistW      = 2;
  localparam int CtrW       = 2;

  localparam logic [WindowW-1:0] WindowReset = 16'd15;

  // Component predictors, in tie-break order.
  typedef enum logic [PredIdxW-1:0] {
    PRED_TAKEN     = 3'd0,
    PRED_NOT_TAKEN = 3'd1,
    PRED_INVERSE   = 3'd2,
    PRED_LAST      = 3'd3,
    PRED_BIMODAL   = 3'd4,
    PRED_TWO_LEVEL = 3'd5,
    PRED_TWO_BACK  = 3'd6
  } pred_e;

  typedef logic [CtrW-1:0] ctr_t;

endpackage

// ----- src/tbp_if.sv -----
// Channel interfaces of the tournament branch predictor: address in,
// result out, window configuration. Depends on tbp_pkg.
interface tbp_addr_if #(
  parameter int AddrW = 48
) ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] fetch_address;

  modport source (output valid, output fetch_address, input ready);
  modport sink   (input valid, input fetch_address, output ready);
endinterface

interface tbp_result_if import tbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 outcome_valid;
  logic                 outcome_taken;
  logic                 combined_correct;
  logic                 next_prediction;
  logic [PredIdxW-1:0]  chosen_predictor;
  logic [OutCountW-1:0] combined_hits;
  logic [OutCountW-1:0] resolved_count;

  modport source (output valid, output outcome_valid, output outcome_taken,
                  output combined_correct, output next_prediction,
                  output chosen_predictor, output combined_hits,
                  output resolved_count, input ready);
  modport sink   (input valid, input outcome_valid, input outcome_taken,
                  input combined_correct, input next_prediction,
                  input chosen_predictor, input combined_hits,
                  input resolved_count, output ready);
endinterface

interface tbp_cfg_if import tbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WindowW-1:0] sequential_window;

  modport source (output valid, output sequential_window, input ready);
  modport sink   (input valid, input sequential_window, output ready);
endinterface

// ----- src/tournament_branch_predictor.sv -----
// Tournament branch predictor, best of seven, with address-step outcome
// resolution. Depends on tbp_pkg and the channel interfaces in tbp_if.sv.
//
//   channel   dir  modport  word
//   addr_i    in   sink     fetch_address
//   cfg_i     in   sink     sequential_window (always ready)
//   result_o  out  source   outcome, guesses, chosen predictor, counts
//
// One word per cycle sustained while the result side is ready; a word passes
// the input register, then the result register, and the result register
// takes a new word while the old one drains. All predictor state updates in the
// single pass between the two registers.
// Reset clears all predictor state, the window returns to 15.
// A stalled result holds in the result register; the input register takes a
// word while it is empty or while the result register is empty or drains in
// the same cycle.
module tournament_branch_predictor import tbp_pkg::*; #(
  parameter int ADDRESS_BITS   = 48,
  parameter int HIT_COUNT_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tbp_addr_if.sink     addr_i,
  tbp_cfg_if.sink      cfg_i,
  tbp_result_if.source result_o
);

  typedef logic [HIT_COUNT_BITS-1:0] cnt_t;

  // pipeline control
  logic                    s1_valid_q;
  logic [ADDRESS_BITS-1:0] s1_addr_q;
  logic                    s2_valid_q;
  logic                    s2_free;
  logic                    advance;

  // predictor state
  logic [WindowW-1:0]      window_q;
  logic [ADDRESS_BITS-1:0] prev_addr_q;
  logic                    have_prev_q;
  cnt_t                    hits_q [NumPred];
  cnt_t                    hits_d [NumPred];
  cnt_t                    comb_hits_q, comb_hits_d;
  cnt_t                    total_q, total_d;
  ctr_t                    bimodal_q, bimodal_d;
  ctr_t                    pattern_q [4];
  ctr_t                    pattern_d [4];
  logic [HistW-1:0]        hist_q, hist_d;
  logic                    guess_q, guess_d;
  pred_e                   sel_q, sel_d;

  // result register
  logic                    r_outcome_valid_q;
  logic                    r_taken_q;
  logic                    r_correct_q;

  logic                    taken;
  logic                    correct;
  logic [ADDRESS_BITS-1:0] addr_diff;
  logic [NumPred-1:0]      guess_now;
  logic [NumPred-1:0]      guess_next;

  assign s2_free    = !s2_valid_q || result_o.ready;
  assign advance    = s1_valid_q && s2_free;
  assign addr_i.ready = !s1_valid_q || s2_free;
  assign cfg_i.ready  = 1'b1;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic ctr_t sat2(ctr_t c, logic up);
    if (up) begin
      return (c == '1) ? c : c + ctr_t'(1);
    end
    return (c == '0) ? c : c - ctr_t'(1);
  endfunction

  // resolve the outcome from the address step
  assign addr_diff = s1_addr_q - prev_addr_q;
  assign taken = (s1_addr_q < prev_addr_q) ||
                 (addr_diff > ADDRESS_BITS'(window_q));
  assign correct = (guess_q == taken);

  // guesses from the current state
  always_comb begin
    guess_now = '0;
    guess_now[PRED_TAKEN]     = 1'b1;
    guess_now[PRED_NOT_TAKEN] = 1'b0;
    guess_now[PRED_INVERSE]   = (total_q == '0) ? 1'b0 : !hist_q[0];
    guess_now[PRED_LAST]      = hist_q[0];
    guess_now[PRED_BIMODAL]   = bimodal_q[1];
    guess_now[PRED_TWO_LEVEL] = pattern_q[hist_q][1];
    guess_now[PRED_TWO_BACK]  = hist_q[1];
  end

  // state update for one resolved outcome
  always_comb begin
    for (int k = 0; k < NumPred; k++) begin
      hits_d[k] = (guess_now[k] == taken) ? sat_inc(hits_q[k]) : hits_q[k];
    end
    comb_hits_d = correct ? sat_inc(comb_hits_q) : comb_hits_q;
    total_d     = sat_inc(total_q);
    bimodal_d   = sat2(bimodal_q, taken);
    for (int k = 0; k < 4; k++) begin
      pattern_d[k] = (hist_q == HistW'(k)) ? sat2(pattern_q[k], taken) : pattern_q[k];
    end
    hist_d = {hist_q[0], taken};
  end

  // guesses from the updated state
  always_comb begin
    guess_next = '0;
    guess_next[PRED_TAKEN]     = 1'b1;
    guess_next[PRED_NOT_TAKEN] = 1'b0;
    guess_next[PRED_INVERSE]   = (total_d == '0) ? 1'b0 : !hist_d[0];
    guess_next[PRED_LAST]      = hist_d[0];
    guess_next[PRED_BIMODAL]   = bimodal_d[1];
    guess_next[PRED_TWO_LEVEL] = pattern_d[hist_d][1];
    guess_next[PRED_TWO_BACK]  = hist_d[1];
  end

  // most hits wins; the lower index keeps a tie at every level of the tree
  always_comb begin
    pred_e i01, i23, i45, i03, i46;
    cnt_t  v01, v23, v45, v03, v46;
    i01 = (hits_d[1] > hits_d[0]) ? PRED_NOT_TAKEN : PRED_TAKEN;
    v01 = (hits_d[1] > hits_d[0]) ? hits_d[1] : hits_d[0];
    i23 = (hits_d[3] > hits_d[2]) ? PRED_LAST : PRED_INVERSE;
    v23 = (hits_d[3] > hits_d[2]) ? hits_d[3] : hits_d[2];
    i45 = (hits_d[5] > hits_d[4]) ? PRED_TWO_LEVEL : PRED_BIMODAL;
    v45 = (hits_d[5] > hits_d[4]) ? hits_d[5] : hits_d[4];
    i03 = (v23 > v01) ? i23 : i01;
    v03 = (v23 > v01) ? v23 : v01;
    i46 = (hits_d[6] > v45) ? PRED_TWO_BACK : i45;
    v46 = (hits_d[6] > v45) ? hits_d[6] : v45;
    sel_d   = (v46 > v03) ? i46 : i03;
    guess_d = guess_next[sel_d];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_i.valid) begin
      window_q <= cfg_i.sequential_window;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (addr_i.ready) begin
      s1_valid_q <= addr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_i.valid && addr_i.ready) begin
      s1_addr_q <= addr_i.fetch_address;
    end
  end

  // predictor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_addr_q <= '0;
      have_prev_q <= 1'b0;
      for (int k = 0; k < NumPred; k++) begin
        hits_q[k] <= '0;
      end
      comb_hits_q <= '0;
      total_q     <= '0;
      bimodal_q   <= '0;
      for (int k = 0; k < 4; k++) begin
        pattern_q[k] <= '0;
      end
      hist_q  <= '0;
      guess_q <= 1'b0;
      sel_q   <= PRED_TAKEN;
    end else if (advance) begin
      prev_addr_q <= s1_addr_q;
      have_prev_q <= 1'b1;
      // first address only seeds the previous address
      if (have_prev_q) begin
        hits_q      <= hits_d;
        comb_hits_q <= comb_hits_d;
        total_q     <= total_d;
        bimodal_q   <= bimodal_d;
        pattern_q   <= pattern_d;
        hist_q      <= hist_d;
        guess_q     <= guess_d;
        sel_q       <= sel_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      r_outcome_valid_q <= have_prev_q;
      r_taken_q         <= have_prev_q && taken;
      r_correct_q       <= have_prev_q && correct;
    end
  end

  // counts and guess are read back from the state registers, which hold
  // until the next word advances, i.e. while the result stalls
  assign result_o.valid            = s2_valid_q;
  assign result_o.outcome_valid    = r_outcome_valid_q;
  assign result_o.outcome_taken    = r_taken_q;
  assign result_o.combined_correct = r_correct_q;
  assign result_o.next_prediction  = guess_q;
  assign result_o.chosen_predictor = sel_q;
  assign result_o.combined_hits    = OutCountW'(comb_hits_q);
  assign result_o.resolved_count   = OutCountW'(total_q);

endmodule

// ----- bench/tb_tournament_branch_predictor.sv -----
// Self-checking bench for tournament_branch_predictor: fetch addresses in, one
// resolved outcome and combined guess out per word, checked against a local model.
// Depends on tbp_pkg, the channel interfaces in tbp_if.sv and the top level.
module tb_tournament_branch_predictor;
  import tbp_pkg::*;

  localparam int AddrBits = 48;
  localparam logic [63:0] AddrMax = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned HitMax = 64'hFFFF_FFFF;
  localparam int NumDirected = 23;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 66;

  typedef struct packed {
    logic                 outcome_valid;
    logic                 outcome_taken;
    logic                 combined_correct;
    logic                 next_prediction;
    pred_e                chosen_predictor;
    logic [OutCountW-1:0] combined_hits;
    logic [OutCountW-1:0] resolved_count;
  } branch_result_t;

  typedef struct packed {
    logic [AddrBits-1:0] fetch_address;
    logic                typed;
    branch_result_t      want;
  } stim_row_t;

  localparam branch_result_t Unchecked = '0;

  logic clk_i;
  logic rst_ni;

  tbp_addr_if #(.AddrW(AddrBits)) addr_ch ();
  tbp_cfg_if                      cfg_ch ();
  tbp_result_if                   res_ch ();

  tournament_branch_predictor #(
    .ADDRESS_BITS  (AddrBits),
    .HIT_COUNT_BITS(32)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (addr_ch),
    .cfg_i   (cfg_ch),
    .result_o(res_ch)
  );

  // Model state of the block
  logic [15:0]         window_cfg;
  logic [AddrBits-1:0] last_fetch;
  bit                  seen_first;
  longint unsigned     pred_hits [NumPred];
  longint unsigned     right_total;
  longint unsigned     outcome_count;
  ctr_t                bimodal;
  ctr_t                pattern_ctr [4];
  logic [HistW-1:0]    history;
  logic                guess;
  pred_e               chosen;

  branch_result_t      expected_outcomes [$];
  logic [AddrBits-1:0] gen_last;
  bit                  idle_on;
  int                  errors;
  int                  words_checked;
  int                  taken_seen;
  int                  windows_used;
  bit                  leader_seen [NumPred];
  int                  stall_left;

  stim_row_t directed_rows [NumDirected] = '{
    '{48'h0000_0000_0000, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, PRED_TAKEN, 32'd0, 32'd0}},
    '{48'h0000_0000_000F, 1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b0, PRED_NOT_TAKEN, 32'd1, 32'd1}},
    '{48'h0000_0000_001F, 1'b0, Unchecked},
    '{48'h0000_0000_001E, 1'b0, Unchecked},
    '{48'hFFFF_FFFF_FFFF, 1'b0, Unchecked},
    '{48'h0000_0000_0000, 1'b0, Unchecked},
    '{48'h0000_0000_0000, 1'b0, Unchecked},
    '{48'hFFFF_FFFF_FFF0, 1'b0, Unchecked},
    '{48'hFFFF_FFFF_FFFF, 1'b0, Unchecked},
    '{48'hAAAA_AAAA_AAAA, 1'b0, Unchecked},
    '{48'h5555_5555_5555, 1'b0, Unchecked},
    '{48'h0000_0000_1000, 1'b0, Unchecked},
    '{48'h0000_0000_1001, 1'b0, Unchecked},
    '{48'h0000_0000_1000, 1'b0, Unchecked},
    '{48'h0000_0000_1001, 1'b0, Unchecked},
    '{48'h0000_0000_1000, 1'b0, Unchecked},
    '{48'h0000_0000_1001, 1'b0, Unchecked},
    '{48'h0000_0000_1000, 1'b0, Unchecked},
    '{48'h0000_0000_100F, 1'b0, Unchecked},
    '{48'h0000_0000_1000, 1'b0, Unchecked},
    '{48'h8000_0000_0000, 1'b0, Unchecked},
    '{48'h7FFF_FFFF_FFFF, 1'b0, Unchecked},
    '{48'h8000_0000_000F, 1'b0, Unchecked}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_tournament_branch_predictor failed");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic ctr_t bump(ctr_t c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function automatic logic guess_of(pred_e p);
    case (p)
      PRED_TAKEN:     return 1'b1;
      PRED_NOT_TAKEN: return 1'b0;
      PRED_INVERSE:   return (outcome_count == 0) ? 1'b0 : ~history[0];
      PRED_LAST:      return history[0];
      PRED_BIMODAL:   return bimodal[1];
      PRED_TWO_LEVEL: return pattern_ctr[history][1];
      default:        return history[1];
    endcase
  endfunction

  task automatic reset_model();
    window_cfg = WindowReset;
    last_fetch = '0;
    seen_first = 1'b0;
    foreach (pred_hits[k]) pred_hits[k] = 0;
    right_total = 0;
    outcome_count = 0;
    bimodal = '0;
    foreach (pattern_ctr[k]) pattern_ctr[k] = '0;
    history = '0;
    guess = 1'b0;
    chosen = PRED_TAKEN;
  endtask

  // Resolve one fetch address and return the word the block should emit.
  task automatic resolve_fetch(input logic [AddrBits-1:0] fa, output branch_result_t r);
    logic taken;
    logic g [NumPred];
    int   best;
    r = '0;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_fetch = fa;
    end else begin
      taken = (fa < last_fetch) || ((fa - last_fetch) > AddrBits'(window_cfg));
      last_fetch = fa;
      for (int k = 0; k < NumPred; k++) g[k] = guess_of(pred_e'(k));
      for (int k = 0; k < NumPred; k++)
        if (g[k] == taken && pred_hits[k] < HitMax) pred_hits[k]++;
      r.combined_correct = (guess == taken);
      if (r.combined_correct && right_total < HitMax) right_total++;
      if (outcome_count < HitMax) outcome_count++;
      bimodal = bump(bimodal, taken);
      pattern_ctr[history] = bump(pattern_ctr[history], taken);
      history = {history[0], taken};
      best = 0;
      for (int k = 1; k < NumPred; k++)
        if (pred_hits[k] > pred_hits[best]) best = k;
      chosen = pred_e'(best);
      guess = guess_of(chosen);
      leader_seen[best] = 1'b1;
      r.outcome_valid = 1'b1;
      r.outcome_taken = taken;
      if (taken) taken_seen++;
    end
    r.next_prediction = guess;
    r.chosen_predictor = chosen;
    r.combined_hits = right_total[OutCountW-1:0];
    r.resolved_count = outcome_count[OutCountW-1:0];
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick an address whose step from the last one yields the wanted outcome.
  function automatic logic [AddrBits-1:0] next_fetch(logic want_taken);
    logic [63:0] p;
    logic [63:0] step;
    logic [63:0] floor_fwd;
    logic [63:0] span;
    p = 64'(gen_last);
    if (!want_taken) begin
      step = ($urandom_range(3) == 0) ? 64'(window_cfg) : 64'($urandom_range(window_cfg, 0));
      if (p + step > AddrMax) step = 0;
      return AddrBits'(p + step);
    end
    floor_fwd = p + 64'(window_cfg) + 1;
    if (floor_fwd <= AddrMax && (p == 0 || $urandom_range(1) == 1)) begin
      span = AddrMax - floor_fwd;
      case ($urandom_range(2))
        0:       return AddrBits'(floor_fwd);
        1:       return AddrBits'(floor_fwd + (64'($urandom_range(255)) % (span + 1)));
        default: return AddrBits'(floor_fwd + (rand64() % (span + 1)));
      endcase
    end
    if ($urandom_range(2) == 0) return AddrBits'(p - 1);
    return AddrBits'(p - (1 + rand64() % p));
  endfunction

  task automatic push_address(input logic [AddrBits-1:0] fa, input logic typed,
                              input branch_result_t want);
    int             gap;
    branch_result_t predicted;
    gap = idle_length();
    if (gap > 0) begin
      addr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    addr_ch.valid <= 1'b1;
    addr_ch.fetch_address <= fa;
    @(posedge clk_i);
    while (!addr_ch.ready) @(posedge clk_i);
    resolve_fetch(fa, predicted);
    expected_outcomes.insert(expected_outcomes.size(), typed ? want : predicted);
    gen_last = fa;
  endtask

  task automatic drain_results();
    addr_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [15:0] w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.sequential_window <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    window_cfg = w;
    windows_used++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Result sink: random stalls, sized like the source gaps
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_length();
      res_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    branch_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected", $time);
      end else begin
        want = expected_outcomes.pop_front();
        words_checked++;
        check_field("outcome_valid", 32'(want.outcome_valid), 32'(res_ch.outcome_valid));
        check_field("outcome_taken", 32'(want.outcome_taken), 32'(res_ch.outcome_taken));
        check_field("combined_correct", 32'(want.combined_correct),
                    32'(res_ch.combined_correct));
        check_field("next_prediction", 32'(want.next_prediction),
                    32'(res_ch.next_prediction));
        check_field("chosen_predictor", 32'(want.chosen_predictor),
                    32'(res_ch.chosen_predictor));
        check_field("combined_hits", want.combined_hits, res_ch.combined_hits);
        check_field("resolved_count", want.resolved_count, res_ch.resolved_count);
      end
    end
  end

  initial begin
    logic [15:0] w;
    logic [3:0]  pattern;
    int          pattern_len;
    int          noise_pct;
    int          leaders;
    rst_ni <= 1'b0;
    addr_ch.valid <= 1'b0;
    addr_ch.fetch_address <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.sequential_window <= '0;
    idle_on = 1'b1;
    errors = 0;
    words_checked = 0;
    taken_seen = 0;
    windows_used = 1;
    gen_last = '0;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_address(directed_rows[i].fetch_address, directed_rows[i].typed,
                   directed_rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0:       w = 16'd0;
        1:       w = 16'hFFFF;
        2:       w = 16'd1;
        3:       w = WindowReset;
        4:       w = 16'd255;
        default: w = 16'($urandom_range(16'hFFFF));
      endcase
      write_window(w);
      // hold both sides busy in a couple of phases
      idle_on = (ph != 2 && ph != 6);
      pattern = '0;
      pattern_len = 1;
      noise_pct = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 22 == 0) begin
          pattern = 4'($urandom_range(15));
          pattern_len = $urandom_range(4, 1);
          noise_pct = $urandom_range(20);
        end
        if ($urandom_range(99) < noise_pct)
          push_address(AddrBits'(rand64()), 1'b0, Unchecked);
        else
          push_address(next_fetch(pattern[i % pattern_len]), 1'b0, Unchecked);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    leaders = 0;
    foreach (leader_seen[k]) leaders += leader_seen[k];
    $display("Checked %0d result words, %0d taken outcomes, %0d window settings",
             words_checked, taken_seen, windows_used);
    $display("%0d of %0d component predictors led the tournament at some point",
             leaders, NumPred);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("tb_tournament_branch_predictor passed");
    end else begin
      $display("tb_tournament_branch_predictor failed");
    end
    $finish;
  end

endmodule
